// File: sv/pdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_pkg: shared types, constants and functions for pose dead reckoning
// Field widths, request codes, quarter-wave sine table, whole-cm conversion.
// ----------------------------------------------------------------------------
package pdr_pkg;

   // position and trig precision
   localparam int POS_WIDTH = 24;
   localparam int TRIG_BITS = 16;

   // fixed field widths
   localparam int FUNC_W  = 2;
   localparam int DIST_W  = 16;
   localparam int DELTA_W = 10;
   localparam int HEAD_W  = 9;
   localparam int TURN_W  = 9;
   localparam int CM_W    = 16;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TURN = 2'd2;

   // step arithmetic widths
   localparam int PROD_W  = TRIG_BITS + DIST_W;
   localparam int FRAC_K  = TRIG_BITS - 1;
   localparam int RSTEP_W = PROD_W + 1 - FRAC_K;
   localparam int STEP_W  = RSTEP_W + 1;
   localparam int SUM_W   = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 1;
   localparam longint POS_MAX = (longint'(1) << (POS_WIDTH - 1)) - 1;
   localparam longint POS_MIN = -POS_MAX - 1;

   // table scaling to TRIG_BITS
   localparam int ROM_SHL = (TRIG_BITS >= 16) ? TRIG_BITS - 16 : 0;
   localparam int ROM_SHR = (TRIG_BITS < 16) ? 16 - TRIG_BITS : 0;
   localparam int ROM_RND = (ROM_SHR > 0) ? (1 << (ROM_SHR - 1)) : 0;

   typedef struct packed {
      logic                 neg;
      logic [TRIG_BITS-1:0] mag;
   } trig_type;

   // sin(d) in Q1.15 for d = 0..90 degrees
   localparam logic [15:0] SINE_ROM [0:90] = '{
          16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
       16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
       16'd7927,  16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
   };

   // signed sine of a heading in 0..359, fold into the first quadrant
   function automatic trig_type sine_of(input logic [HEAD_W-1:0] h);
      logic [HEAD_W-1:0] idx;
      logic [31:0]       t;
      trig_type          r;
      if (h <= 9'd90) begin
         idx = h;
      end else if (h <= 9'd180) begin
         idx = 9'd180 - h;
      end else if (h <= 9'd270) begin
         idx = h - 9'd180;
      end else begin
         idx = 9'd360 - h;
      end
      t = 32'(SINE_ROM[idx[6:0]]);
      if (ROM_SHR == 0) begin
         t = t << ROM_SHL;
      end else begin
         t = (t + 32'(ROM_RND)) >> ROM_SHR;
      end
      r.neg = (h > 9'd180);
      r.mag = t[TRIG_BITS-1:0];
      return r;
   endfunction

   // (p + 0.5 cm) truncated toward zero, saturated to whole-cm range
   function automatic logic signed [CM_W-1:0] to_cm(input logic signed [POS_WIDTH-1:0] p);
      logic signed [POS_WIDTH:0] v;
      logic        [POS_WIDTH:0] mag;
      logic        [POS_WIDTH:0] q;
      logic signed [POS_WIDTH:0] c;
      logic signed [CM_W-1:0]    r;
      v   = $signed({p[POS_WIDTH-1], p}) + $signed((POS_WIDTH+1)'(128));
      mag = v[POS_WIDTH] ? (POS_WIDTH+1)'(-v) : (POS_WIDTH+1)'(v);
      q   = mag >> 8;
      c   = v[POS_WIDTH] ? -$signed(q) : $signed(q);
      if (c > $signed((POS_WIDTH+1)'(32767))) begin
         r = 16'sh7fff;
      end else if (c < -$signed((POS_WIDTH+1)'(32768))) begin
         r = 16'sh8000;
      end else begin
         r = c[CM_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/pdr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_req_if / pdr_rsp_if: request and response channels
// Valid/ready handshake carrying the pose request and pose report payloads.
// ----------------------------------------------------------------------------
interface pdr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [pdr_pkg::FUNC_W-1:0]    func;
   logic        [pdr_pkg::DIST_W-1:0]    distance;
   logic signed [pdr_pkg::DELTA_W-1:0]   angle_delta;
   logic signed [pdr_pkg::POS_WIDTH-1:0] new_x;
   logic signed [pdr_pkg::POS_WIDTH-1:0] new_y;
   logic        [pdr_pkg::HEAD_W-1:0]    new_heading;
   logic        [pdr_pkg::HEAD_W-1:0]    target_heading;

   modport source (output valid, func, distance, angle_delta, new_x, new_y,
                   new_heading, target_heading, input ready);
   modport sink (input valid, func, distance, angle_delta, new_x, new_y,
                 new_heading, target_heading, output ready);
endinterface

interface pdr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pdr_pkg::POS_WIDTH-1:0] x_now;
   logic signed [pdr_pkg::POS_WIDTH-1:0] y_now;
   logic        [pdr_pkg::HEAD_W-1:0]    heading_now;
   logic signed [pdr_pkg::CM_W-1:0]      x_cm;
   logic signed [pdr_pkg::CM_W-1:0]      y_cm;
   logic signed [pdr_pkg::TURN_W-1:0]    turn;

   modport source (output valid, x_now, y_now, heading_now, x_cm, y_cm, turn,
                   input ready);
   modport sink (input valid, x_now, y_now, heading_now, x_cm, y_cm, turn,
                 output ready);
endinterface
`default_nettype wire

// File: sv/pdr_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_axis: one position axis update
// Adds distance times a signed trig value, rounded half away from zero to
// 8 fraction bits, to the position and saturates to the position range.
// ----------------------------------------------------------------------------
module pdr_axis (
   input  wire logic signed [pdr_pkg::POS_WIDTH-1:0] pos,
   input  wire logic        [pdr_pkg::DIST_W-1:0]    distance,
   input  wire pdr_pkg::trig_type                    trig,
   output logic signed      [pdr_pkg::POS_WIDTH-1:0] pos_moved
);
   localparam int PROD_W  = pdr_pkg::PROD_W;
   localparam int FRAC_K  = pdr_pkg::FRAC_K;
   localparam int RSTEP_W = pdr_pkg::RSTEP_W;
   localparam int STEP_W  = pdr_pkg::STEP_W;
   localparam int SUM_W   = pdr_pkg::SUM_W;
   localparam int POS_W   = pdr_pkg::POS_WIDTH;

   localparam logic [PROD_W:0]         STEP_HALF = (PROD_W+1)'(1) << (FRAC_K - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI    = SUM_W'(pdr_pkg::POS_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO    = SUM_W'(pdr_pkg::POS_MIN);

   logic        [PROD_W-1:0]  prod;
   logic        [PROD_W:0]    rnd_sum;
   logic        [RSTEP_W-1:0] rounded;
   logic signed [STEP_W-1:0]  step;
   logic signed [SUM_W-1:0]   sum;

   always_comb begin
      prod    = PROD_W'(trig.mag) * PROD_W'(distance);
      rnd_sum = {1'b0, prod} + STEP_HALF;
      rounded = rnd_sum[PROD_W:FRAC_K];
      step    = trig.neg ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
      sum     = SUM_W'(pos) + SUM_W'(step);
      if (sum > SAT_HI) begin
         pos_moved = SAT_HI[POS_W-1:0];
      end else if (sum < SAT_LO) begin
         pos_moved = SAT_LO[POS_W-1:0];
      end else begin
         pos_moved = sum[POS_W-1:0];
      end
   end
endmodule
`default_nettype wire

// File: sv/pose_dead_reckoning_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pose_dead_reckoning_top: robot pose keeper by dead reckoning
// Move and set requests update x, y and heading; every request reports the
// pose, whole-cm position and shortest turn.
// ----------------------------------------------------------------------------
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    func, distance, angle_delta, new_x/y/heading,
//                                   target_heading
//   rsp_chan   out   valid/ready    x_now, y_now, heading_now, x_cm, y_cm, turn
//
// One request per cycle when not stalled. The heading wrap, sine table lookup,
// 16x16 multiply and saturating add run in the cycle a request is accepted;
// pose state and the response register load at that edge, so the response
// follows in the next cycle. Whole-cm values are rounded from the response
// register, which stalls the request side only while it holds an untaken
// response. Synchronous reset zeroes the pose and empties the response register.
// ----------------------------------------------------------------------------
module pose_dead_reckoning_top (
   input wire logic  clock,
   input wire logic  reset,
   pdr_req_if.sink   req_chan,
   pdr_rsp_if.source rsp_chan
);
   localparam int POS_W  = pdr_pkg::POS_WIDTH;
   localparam int HEAD_W = pdr_pkg::HEAD_W;
   localparam int HS_W   = HEAD_W + 2;

   localparam logic [HEAD_W-1:0]       HEAD_360 = 9'd360;
   localparam logic [HEAD_W:0]         COS_90   = 10'd90;
   localparam logic [HEAD_W:0]         COS_360  = 10'd360;
   localparam logic signed [HS_W-1:0]  HS_360   = 11'sd360;
   localparam logic signed [HS_W-1:0]  HS_720   = 11'sd720;
   localparam logic signed [HS_W-1:0]  HS_180   = 11'sd180;

   // pose state
   logic signed [POS_W-1:0]  pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]  pos_y_ff, pos_y_in;
   logic        [HEAD_W-1:0] heading_ff, heading_in;

   // response register
   logic                              rsp_valid_ff;
   logic signed [POS_W-1:0]           x_now_ff, y_now_ff;
   logic        [HEAD_W-1:0]          heading_now_ff;
   logic signed [pdr_pkg::TURN_W-1:0] turn_ff, turn_in;

   logic                    accept;
   logic signed [HS_W-1:0]  h_sum;
   logic signed [HS_W-1:0]  h_fix;
   logic        [HEAD_W-1:0] h_move;
   logic        [HEAD_W:0]   hc_sum;
   logic        [HEAD_W:0]   hc_fix;
   logic        [HEAD_W-1:0] h_cos;
   logic        [HEAD_W-1:0] h_set;
   logic        [HEAD_W-1:0] h_target;
   logic signed [HS_W-1:0]  diff;
   logic signed [HS_W-1:0]  diff_fix;
   pdr_pkg::trig_type       trig_cos, trig_sin;
   logic signed [POS_W-1:0] x_moved, y_moved;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // heading after a move, wrapped into 0..359
   always_comb begin
      h_sum = $signed({2'b00, heading_ff}) + HS_W'(req_chan.angle_delta);
      if (h_sum < -HS_360) begin
         h_fix = h_sum + HS_720;
      end else if (h_sum < 0) begin
         h_fix = h_sum + HS_360;
      end else if (h_sum >= HS_720) begin
         h_fix = h_sum - HS_720;
      end else if (h_sum >= HS_360) begin
         h_fix = h_sum - HS_360;
      end else begin
         h_fix = h_sum;
      end
      h_move = h_fix[HEAD_W-1:0];

      // cos(h) = sin(h + 90)
      hc_sum = {1'b0, h_move} + COS_90;
      hc_fix = (hc_sum >= COS_360) ? hc_sum - COS_360 : hc_sum;
      h_cos  = hc_fix[HEAD_W-1:0];

      trig_cos = pdr_pkg::sine_of(h_cos);
      trig_sin = pdr_pkg::sine_of(h_move);

      h_set    = (req_chan.new_heading >= HEAD_360) ?
                 req_chan.new_heading - HEAD_360 : req_chan.new_heading;
      h_target = (req_chan.target_heading >= HEAD_360) ?
                 req_chan.target_heading - HEAD_360 : req_chan.target_heading;

      // shortest turn, keep an exact half turn as is
      diff = $signed({2'b00, h_target}) - $signed({2'b00, heading_ff});
      if (diff < -HS_180) begin
         diff_fix = diff + HS_360;
      end else if (diff > HS_180) begin
         diff_fix = diff - HS_360;
      end else begin
         diff_fix = diff;
      end
   end

   pdr_axis u_axis_x (
      .pos       (pos_x_ff),
      .distance  (req_chan.distance),
      .trig      (trig_cos),
      .pos_moved (x_moved)
   );

   pdr_axis u_axis_y (
      .pos       (pos_y_ff),
      .distance  (req_chan.distance),
      .trig      (trig_sin),
      .pos_moved (y_moved)
   );

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      turn_in    = '0;
      case (req_chan.func)
         pdr_pkg::FUNC_MOVE: begin
            pos_x_in   = x_moved;
            pos_y_in   = y_moved;
            heading_in = h_move;
         end
         pdr_pkg::FUNC_SET: begin
            pos_x_in   = req_chan.new_x;
            pos_y_in   = req_chan.new_y;
            heading_in = h_set;
         end
         pdr_pkg::FUNC_TURN: begin
            turn_in = diff_fix[pdr_pkg::TURN_W-1:0];
         end
         default: begin
            // unused code: report the pose unchanged
            turn_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_now_ff       <= pos_x_in;
         y_now_ff       <= pos_y_in;
         heading_now_ff <= heading_in;
         turn_ff        <= turn_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.x_now       = x_now_ff;
   assign rsp_chan.y_now       = y_now_ff;
   assign rsp_chan.heading_now = heading_now_ff;
   assign rsp_chan.x_cm        = pdr_pkg::to_cm(x_now_ff);
   assign rsp_chan.y_cm        = pdr_pkg::to_cm(y_now_ff);
   assign rsp_chan.turn        = turn_ff;

   // heading never leaves 0..359
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff < HEAD_360)
      else $error("heading out of range");

   // every accepted request produces a response next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted request without response");

   // turn is zero unless the request was a turn query
   a_turn_zero: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.func != pdr_pkg::FUNC_TURN |=> rsp_chan.turn == '0)
      else $error("nonzero turn on non-query request");

   // set pose loads x and y verbatim
   a_set_load: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.func == pdr_pkg::FUNC_SET |=>
         pos_x_ff == $past(req_chan.new_x) && pos_y_ff == $past(req_chan.new_y))
      else $error("set pose not loaded");

   // reported turn stays within a half turn
   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.turn >= -9'sd180 && rsp_chan.turn <= 9'sd180)
      else $error("turn out of range");
endmodule
`default_nettype wire

// File: verif/pose_dead_reckoning_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_dead_reckoning_top_tb: self-checking bench for the pose keeper
// Drives move, set and turn requests (plus the unused code) through the
// request channel. A scoreboard tracks x, y and heading and predicts every
// response. Sender gaps, receiver stalls and a long back-pressure hold are
// mixed in across several phases.
// ----------------------------------------------------------------------------
module pose_dead_reckoning_top_tb;

   localparam logic [pdr_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 200;
   localparam int RANDOM_PER_PHASE = 200;

   // sin(d) in Q1.15 for d = 0..90, sin(90) = 32768
   localparam int SINE_Q15 [0:90] = '{
          0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
       5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
      11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
      16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
      21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
      25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
      28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
      30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
      32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
      32768
   };

   typedef struct {
      logic        [pdr_pkg::FUNC_W-1:0]    func;
      logic        [pdr_pkg::DIST_W-1:0]    distance;
      logic signed [pdr_pkg::DELTA_W-1:0]   angle_delta;
      logic signed [pdr_pkg::POS_WIDTH-1:0] new_x;
      logic signed [pdr_pkg::POS_WIDTH-1:0] new_y;
      logic        [pdr_pkg::HEAD_W-1:0]    new_heading;
      logic        [pdr_pkg::HEAD_W-1:0]    target_heading;
   } pose_req_type;

   typedef struct {
      logic signed [pdr_pkg::POS_WIDTH-1:0] x_now;
      logic signed [pdr_pkg::POS_WIDTH-1:0] y_now;
      logic        [pdr_pkg::HEAD_W-1:0]    heading_now;
      logic signed [pdr_pkg::CM_W-1:0]      x_cm;
      logic signed [pdr_pkg::CM_W-1:0]      y_cm;
      logic signed [pdr_pkg::TURN_W-1:0]    turn;
   } pose_rsp_type;

   logic clock = 1'b0;
   logic reset;

   pdr_req_if req_chan ();
   pdr_rsp_if rsp_chan ();

   pose_dead_reckoning_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pose_req_type pending_requests [$];
   pose_rsp_type expected_poses [$];

   // tracked pose
   longint pose_x = 0;
   longint pose_y = 0;
   int     pose_heading = 0;

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int hold_seq       = 0;
   int hold_seen;
   int hold_left;
   int quiet_cycles;

   function automatic int wrap_deg(int a);
      int m;
      m = a % 360;
      if (m < 0) m += 360;
      return m;
   endfunction

   function automatic longint sine_deg(int h);
      if (h <= 90) return SINE_Q15[h];
      else if (h <= 180) return SINE_Q15[180 - h];
      else if (h <= 270) return -longint'(SINE_Q15[h - 180]);
      else return -longint'(SINE_Q15[360 - h]);
   endfunction

   // distance times sine, rounded half away from zero back to 8 fraction bits
   function automatic longint move_step(longint travel, longint s);
      longint mag;
      longint r;
      mag = ((s < 0) ? -s : s) * travel;
      r = (mag + 64'sd16384) >>> 15;
      return (s < 0) ? -r : r;
   endfunction

   function automatic longint clamp_pos(longint v);
      if (v > pdr_pkg::POS_MAX) return pdr_pkg::POS_MAX;
      if (v < pdr_pkg::POS_MIN) return pdr_pkg::POS_MIN;
      return v;
   endfunction

   function automatic logic signed [pdr_pkg::CM_W-1:0] whole_cm(longint p);
      longint v;
      longint c;
      v = p + 128;
      c = (v >= 0) ? (v >>> 8) : -((-v) >>> 8);
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      return c[pdr_pkg::CM_W-1:0];
   endfunction

   function automatic pose_rsp_type predict_pose(pose_req_type r);
      pose_rsp_type o;
      int           diff;
      o.turn = '0;
      case (r.func)
         pdr_pkg::FUNC_MOVE: begin
            pose_heading = wrap_deg(pose_heading + int'(r.angle_delta));
            pose_x = clamp_pos(pose_x + move_step(longint'(r.distance),
                                                  sine_deg(wrap_deg(pose_heading + 90))));
            pose_y = clamp_pos(pose_y + move_step(longint'(r.distance),
                                                  sine_deg(pose_heading)));
         end
         pdr_pkg::FUNC_SET: begin
            pose_x = longint'(r.new_x);
            pose_y = longint'(r.new_y);
            pose_heading = wrap_deg(int'(r.new_heading));
         end
         pdr_pkg::FUNC_TURN: begin
            diff = wrap_deg(int'(r.target_heading)) - pose_heading;
            if (diff < -180) diff += 360;
            else if (diff > 180) diff -= 360;
            o.turn = diff[pdr_pkg::TURN_W-1:0];
         end
         default: ;
      endcase
      o.x_now       = pose_x[pdr_pkg::POS_WIDTH-1:0];
      o.y_now       = pose_y[pdr_pkg::POS_WIDTH-1:0];
      o.heading_now = pose_heading[pdr_pkg::HEAD_W-1:0];
      o.x_cm        = whole_cm(pose_x);
      o.y_cm        = whole_cm(pose_y);
      return o;
   endfunction

   function automatic pose_req_type make_req(logic [pdr_pkg::FUNC_W-1:0] func, int travel,
                                             int delta, int x, int y, int nh, int th);
      pose_req_type r;
      r.func           = func;
      r.distance       = travel[pdr_pkg::DIST_W-1:0];
      r.angle_delta    = delta[pdr_pkg::DELTA_W-1:0];
      r.new_x          = x[pdr_pkg::POS_WIDTH-1:0];
      r.new_y          = y[pdr_pkg::POS_WIDTH-1:0];
      r.new_heading    = nh[pdr_pkg::HEAD_W-1:0];
      r.target_heading = th[pdr_pkg::HEAD_W-1:0];
      return r;
   endfunction

   function automatic int pick_coord();
      int roll;
      roll = $urandom_range(9);
      if (roll <= 5) return int'($urandom_range(2000000)) - 1000000;
      // near the rails, so moves can saturate
      if (roll == 6) return int'(pdr_pkg::POS_MAX) - int'($urandom_range(100000));
      if (roll == 7) return int'(pdr_pkg::POS_MIN) + int'($urandom_range(100000));
      return int'($urandom);
   endfunction

   function automatic int pick_heading();
      if ($urandom_range(9) == 0) return $urandom_range(511, 360);
      return $urandom_range(359);
   endfunction

   function automatic pose_req_type random_request();
      int roll;
      int travel;
      int delta;
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) travel = $urandom_range(1) ? 'hFFFF : 0;
      else travel = $urandom_range(16'hFFFF);
      if ($urandom_range(19) == 0) delta = $urandom_range(1023);
      else delta = int'($urandom_range(718)) - 359;
      return make_req((roll < 55) ? pdr_pkg::FUNC_MOVE : (roll < 72) ? pdr_pkg::FUNC_SET :
                      (roll < 92) ? pdr_pkg::FUNC_TURN : FUNC_NOP,
                      travel, delta, pick_coord(), pick_coord(),
                      pick_heading(), pick_heading());
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_poses.size() != 0 || req_chan.valid)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      pose_req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_poses.push_back(predict_pose(make_req(req_chan.func,
               int'(req_chan.distance), int'(req_chan.angle_delta), int'(req_chan.new_x),
               int'(req_chan.new_y), int'(req_chan.new_heading),
               int'(req_chan.target_heading))));
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_requests.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.func           <= nxt.func;
            req_chan.distance       <= nxt.distance;
            req_chan.angle_delta    <= nxt.angle_delta;
            req_chan.new_x          <= nxt.new_x;
            req_chan.new_y          <= nxt.new_y;
            req_chan.new_heading    <= nxt.new_heading;
            req_chan.target_heading <= nxt.target_heading;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response monitor and ready generator
   always @(posedge clock) begin
      pose_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         hold_seen      <= hold_seq;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_poses.size() == 0) begin
               $display("%0t: response with nothing expected, x_now %0d y_now %0d",
                        $time, rsp_chan.x_now, rsp_chan.y_now);
               mismatch_count++;
            end else begin
               want = expected_poses.pop_front();
               check_field("x_now", want.x_now, rsp_chan.x_now);
               check_field("y_now", want.y_now, rsp_chan.y_now);
               check_field("heading_now", want.heading_now, rsp_chan.heading_now);
               check_field("x_cm", want.x_cm, rsp_chan.x_cm);
               check_field("y_cm", want.y_cm, rsp_chan.y_cm);
               check_field("turn", want.turn, rsp_chan.turn);
            end
         end
         if (hold_seen != hold_seq) begin
            hold_seen      <= hold_seq;
            hold_left      <= HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase;
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.func           = '0;
      req_chan.distance       = '0;
      req_chan.angle_delta    = '0;
      req_chan.new_x          = '0;
      req_chan.new_y          = '0;
      req_chan.new_heading    = '0;
      req_chan.target_heading = '0;
      rsp_chan.ready          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, every code, wraps, rounding and saturation
      pending_requests.push_back(make_req(pdr_pkg::FUNC_TURN, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'hFFFF, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'h8000, 90, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 1, -359, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'hFFFF, 359, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'hFFFF, 180, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 1, -1, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_SET, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_TURN, 0, 0, 0, 0, 0, 180));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_SET, 0, 0, 0, 0, 180, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_TURN, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_TURN, 0, 0, 0, 0, 0, 511));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_SET, 0, 0, int'(pdr_pkg::POS_MAX),
                                          int'(pdr_pkg::POS_MIN), 400, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'hFFFF, -40, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'hFFFF, 270, 0, 0, 0, 0));
      pending_requests.push_back(make_req(FUNC_NOP, 'hFFFF, -1, -1, -1, 511, 511));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_SET, 0, 0, -129, 128, 511, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_SET, 0, 0, -384, 127, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'h1234, -512, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'h4321, 511, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_MOVE, 'hFFFF, 45, 0, 0, 0, 0));
      pending_requests.push_back(make_req(pdr_pkg::FUNC_TURN, 0, 0, 0, 0, 0, 359));
      wait_drained();

      // random phases: no idling, sender gaps, receiver stalls, both
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 64 : (phase == 3) ? 26 : 0;
         stall_pct     = (phase == 2) ? 64 : (phase == 3) ? 26 : 0;
         repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
         while (pending_requests.size() != 0) @(negedge clock);
      end
      wait_drained();

      // back-pressure: hold the receiver while the sender keeps offering
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_seq      = hold_seq + 1;
      repeat (40) pending_requests.push_back(random_request());
      wait_drained();

      // sender has paused until everything came back; one more burst
      send_idle_pct = 26;
      stall_pct     = 26;
      repeat (20) pending_requests.push_back(random_request());
      wait_drained();
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && expected_poses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
